// ===== rtl/core/ragr_pkg.sv =====
// Package: shared types, opcodes and controller states for the rational GCD reducer.
`timescale 1ns / 1ps
`default_nettype none
package ragr_pkg;
	localparam int OperandWidth = 32;
	localparam int ResultWidth = 64;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] a_numerator;
		logic [31:0] a_denominator;
		logic        a_negative;
		logic [31:0] b_numerator;
		logic [31:0] b_denominator;
		logic        b_negative;
	} in_item_t;

	typedef struct packed {
		logic [63:0] result_numerator;
		logic [63:0] result_denominator;
		logic        result_negative;
		logic        error;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_COMB,
		ST_DIV1_START,
		ST_DIV1_RUN,
		ST_GCD_START,
		ST_GCD_RUN,
		ST_DIVN_START,
		ST_DIVN_RUN,
		ST_DIVD_START,
		ST_DIVD_RUN,
		ST_OUT
	} state_t;

	// Datapath commands from the controller.
	typedef struct packed {
		logic load;
		logic mul;
		logic comb;
		logic div_start;
		logic [1:0] div_sel;   // 0: num/den, 1: num/g, 2: den/g
		logic div_step;
		logic gcd_start;
		logic gcd_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic early;       // error or zero result, known during combine
		logic div_done;
		logic gcd_done;
	} sts_t;

	localparam logic [1:0] DivSelNum = 2'd0;
	localparam logic [1:0] DivSelNumG = 2'd1;
	localparam logic [1:0] DivSelDenG = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/core/rational_arith_gcd_reduce_top.sv =====
// Top level: rational add/sub/mul/div with Euclid GCD reduction.
// An error or zero result skips the divisions; otherwise the result waits on three
// runs of the shared bit-serial 65-bit divider plus one more run for each Euclid
// pass with a nonzero divisor.
// Throughput: one transaction at a time; the next is taken once the controller is back in idle after the result loads.
// Reset: arst_n asynchronously clears the controller and output valid; payload is not reset.
`timescale 1ns / 1ps
`default_nettype none
module rational_arith_gcd_reduce_top #(
	parameter int OPERAND_WIDTH = ragr_pkg::OperandWidth
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire ragr_pkg::in_item_t in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output ragr_pkg::out_item_t     out_data
);
	import ragr_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic idle;
	logic go;

	assign in_stall = !idle;
	assign go = in_valid && idle;

	ragr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_go(go),
		.out_busy(out_valid && out_stall), .sts(sts), .cmd(cmd), .idle(idle)
	);

	ragr_dp #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_data), .cmd(cmd), .sts(sts), .res(out_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.out_load) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

`ifndef NO_ASSERTIONS
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> idle) else $error("load outside idle");
	a_out_set: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid) else $error("result not presented");
	a_err_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.error) |-> (out_data.result_denominator == 64'd1))
		else $error("error result malformed");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/ragr_ctrl.sv =====
// Controller: sequences load, multiply, combine, divisions, GCD and output.
`timescale 1ns / 1ps
`default_nettype none
module ragr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_go,
	input  wire logic          out_busy,
	input  wire ragr_pkg::sts_t sts,
	output ragr_pkg::cmd_t     cmd,
	output logic               idle
);
	import ragr_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:       if (in_go) state_d = ST_MUL;
			ST_MUL:        state_d = ST_COMB;
			ST_COMB:       state_d = sts.early ? ST_OUT : ST_DIV1_START;
			ST_DIV1_START: state_d = ST_DIV1_RUN;
			ST_DIV1_RUN:   if (sts.div_done) state_d = ST_GCD_START;
			ST_GCD_START:  state_d = ST_GCD_RUN;
			ST_GCD_RUN:    if (sts.gcd_done) state_d = ST_DIVN_START;
			ST_DIVN_START: state_d = ST_DIVN_RUN;
			ST_DIVN_RUN:   if (sts.div_done) state_d = ST_DIVD_START;
			ST_DIVD_START: state_d = ST_DIVD_RUN;
			ST_DIVD_RUN:   if (sts.div_done) state_d = ST_OUT;
			ST_OUT:        if (!out_busy) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		idle = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				cmd.load = in_go;
			end
			ST_MUL:  cmd.mul = 1'b1;
			ST_COMB: cmd.comb = 1'b1;
			ST_DIV1_START: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = DivSelNum;
			end
			ST_DIV1_RUN, ST_DIVN_RUN, ST_DIVD_RUN: cmd.div_step = 1'b1;
			ST_GCD_START: cmd.gcd_start = 1'b1;
			ST_GCD_RUN:   cmd.gcd_step = 1'b1;
			ST_DIVN_START: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = DivSelNumG;
			end
			ST_DIVD_START: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = DivSelDenG;
			end
			ST_OUT: cmd.out_load = !out_busy;
			default: cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/core/ragr_dp.sv =====
// Datapath: operand registers, multiplier, combine, shared divider and GCD unit.
`timescale 1ns / 1ps
`default_nettype none
module ragr_dp #(
	parameter int OPERAND_WIDTH = ragr_pkg::OperandWidth
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ragr_pkg::in_item_t in_item,
	input  wire ragr_pkg::cmd_t    cmd,
	output ragr_pkg::sts_t         sts,
	output ragr_pkg::out_item_t    res
);
	import ragr_pkg::*;

	localparam int W = OPERAND_WIDTH;

	logic [1:0]    op_q;
	logic [W-1:0]  an_q, ad_q, bn_q, bd_q;
	logic          as_q, bs_q;
	logic [63:0]   x_q, y_q, den_q;
	logic          num_hi_q;
	logic [63:0]   num_lo_q;
	logic          neg_q, err_q, zero_q;
	logic [63:0]   g_q, gx_q;
	logic [63:0]   qnum_q;
	logic          qnum_hi_q;

	// Divider state: 65-bit dividend shifted out MSB first.
	logic [64:0]   dv_q, qt_q;
	logic [63:0]   rm_q, dd_q;
	logic [6:0]    dcnt_q;
	logic [1:0]    dsel_q;
	logic          dbusy_q;

	logic [2*W-1:0] p0, p1, p2;
	logic           eb;
	logic [64:0]    sum;
	logic           zc;

	assign p0 = an_q * ((op_q == OP_MUL) ? bn_q : bd_q);
	assign p1 = bn_q * ad_q;
	assign p2 = ad_q * ((op_q == OP_DIV) ? bn_q : bd_q);
	assign eb = (op_q == OP_SUB) ? !bs_q : bs_q;
	assign sum = {1'b0, x_q} + {1'b0, y_q};

	// Zero result, known from the products during combine.
	always_comb begin
		if (op_q == OP_MUL || op_q == OP_DIV) zc = x_q == '0;
		else if (as_q == eb) zc = sum == '0;
		else zc = x_q == y_q;
	end

	// One restoring division step.
	logic [64:0] rsh;
	logic        take;
	assign rsh = {rm_q, dv_q[64]};
	assign take = rsh >= {1'b0, dd_q};

	// GCD by repeated remainder: use divider remainder each pass.
	logic        gbusy_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_item.operation;
			an_q <= in_item.a_numerator[W-1:0];
			ad_q <= in_item.a_denominator[W-1:0];
			bn_q <= in_item.b_numerator[W-1:0];
			bd_q <= in_item.b_denominator[W-1:0];
			as_q <= in_item.a_negative;
			bs_q <= in_item.b_negative;
		end
		if (cmd.mul) begin
			x_q <= 64'(p0);
			y_q <= 64'(p1);
			den_q <= 64'(p2);
			err_q <= (ad_q == '0) || (bd_q == '0) || ((op_q == OP_DIV) && (bn_q == '0));
		end
		if (cmd.comb) begin
			num_hi_q <= 1'b0;
			zero_q <= zc;
			if (op_q == OP_MUL || op_q == OP_DIV) begin
				num_lo_q <= x_q;
				neg_q <= as_q ^ bs_q;
			end else if (as_q == eb) begin
				num_hi_q <= sum[64];
				num_lo_q <= sum[63:0];
				neg_q <= as_q;
			end else if (x_q > y_q) begin
				num_lo_q <= x_q - y_q;
				neg_q <= as_q;
			end else begin
				num_lo_q <= y_q - x_q;
				neg_q <= eb;
			end
		end
	end

	// Divider and GCD sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			gbusy_q <= 1'b0;
			dcnt_q <= '0;
		end else begin
			if (cmd.div_start) begin
				dbusy_q <= 1'b1;
				dcnt_q <= 7'd65;
			end else if (cmd.gcd_start) begin
				gbusy_q <= 1'b1;
				dbusy_q <= rm_q != '0;
				dcnt_q <= 7'd65;
			end else if (dbusy_q && (cmd.div_step || cmd.gcd_step)) begin
				dcnt_q <= dcnt_q - 7'd1;
				if (dcnt_q == 7'd1) begin
					dbusy_q <= 1'b0;
				end
			end else if (gbusy_q && cmd.gcd_step && !dbusy_q) begin
				// restart for next Euclid pass, or finish
				if (rm_q == '0) gbusy_q <= 1'b0;
				else begin
					dbusy_q <= 1'b1;
					dcnt_q <= 7'd65;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rm_q <= '0;
			qt_q <= '0;
			dsel_q <= cmd.div_sel;
			unique case (cmd.div_sel)
				DivSelNum: begin dv_q <= {num_hi_q, num_lo_q}; dd_q <= den_q; end
				DivSelNumG: begin dv_q <= {num_hi_q, num_lo_q}; dd_q <= g_q; end
				default: begin dv_q <= {1'b0, den_q}; dd_q <= g_q; end
			endcase
		end else if (cmd.gcd_start) begin
			// gcd(den, r): g = den, gx = r
			g_q <= den_q;
			gx_q <= rm_q;
			rm_q <= '0;
			qt_q <= '0;
			dv_q <= {1'b0, den_q};
			dd_q <= rm_q;
		end else if (dbusy_q && (cmd.div_step || cmd.gcd_step)) begin
			dv_q <= {dv_q[63:0], 1'b0};
			qt_q <= {qt_q[63:0], take};
			rm_q <= take ? 64'(rsh - {1'b0, dd_q}) : rsh[63:0];
		end else if (gbusy_q && cmd.gcd_step && !dbusy_q) begin
			if (rm_q == '0) g_q <= (gx_q == '0) ? g_q : gx_q;
			else begin
				g_q <= gx_q;
				gx_q <= rm_q;
				dv_q <= {1'b0, gx_q};
				dd_q <= rm_q;
				rm_q <= '0;
			end
		end
		if (!dbusy_q && cmd.div_step && dsel_q == DivSelNumG) begin
			qnum_q <= qt_q[63:0];
			qnum_hi_q <= qt_q[64];
		end
	end

	assign sts.early = err_q || zc;
	assign sts.div_done = cmd.div_step && !dbusy_q;
	assign sts.gcd_done = cmd.gcd_step && !gbusy_q && !dbusy_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (err_q || zero_q) begin
				res.result_numerator <= '0;
				res.result_denominator <= 64'd1;
				res.result_negative <= 1'b0;
			end else begin
				res.result_numerator <= qnum_hi_q ? '1 : qnum_q;
				res.result_denominator <= qt_q[63:0];
				res.result_negative <= neg_q;
			end
			res.error <= err_q;
		end
	end
endmodule
`default_nettype wire
